// ===== rtl/core/wmap_pkg.sv =====
// Package for the maze wall map: sizes, opcodes, cell bit layout, sequencer states,
// store access struct and the cell address function.
// No dependencies; every other file of the block imports it.
package wmap_pkg;

    // Built grid size
    localparam int MAX_WIDTH  = 16;
    localparam int MAX_HEIGHT = 16;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int GRID_W    = 5;
    localparam int DIM_W     = GRID_W + 1;
    localparam int CFG_IDX_W = 4;
    localparam int CELL_W    = 5;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);
    localparam logic [GRID_W-1:0]    GRID_RESET      = GRID_W'(16);

    // Cell word: bit0 north, bit1 east, bit2 south, bit3 west, bit4 known
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam cell_t MASK_N = 5'b00001;
    localparam cell_t MASK_E = 5'b00010;
    localparam cell_t MASK_S = 5'b00100;
    localparam cell_t MASK_W = 5'b01000;
    localparam cell_t MASK_K = 5'b10000;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_CELL  = 2'd0,
        OP_REMOVE_WALL = 2'd1,
        OP_MOVE_QUERY  = 2'd2,
        OP_READ_CELL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_FIN
    } state_t;

    // One access to the wall store
    typedef struct packed {
        logic  en;
        logic  we;
        addr_t addr;
        cell_t wdata;
    } store_req_t;

    // Linear address of an on-grid cell
    function automatic addr_t cell_addr(input logic [GRID_W-1:0] x,
                                        input logic [GRID_W-1:0] y);
        cell_addr = ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

endpackage

// ===== rtl/core/wmap_ifs.sv =====
// Channel interfaces of the maze wall map: request, result and register write.
// Depends on wmap_pkg for field widths.

interface wmap_cmd_if import wmap_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic signed [COORD_W-1:0]  from_x;
    logic signed [COORD_W-1:0]  from_y;
    logic signed [COORD_W-1:0]  to_x;
    logic signed [COORD_W-1:0]  to_y;
    logic                       wall_north;
    logic                       wall_east;
    logic                       wall_south;
    logic                       wall_west;
    logic                       diag_en;

    modport source (output valid, opcode, from_x, from_y, to_x, to_y, wall_north,
                    wall_east, wall_south, wall_west, diag_en, input ready);
    modport sink   (input valid, opcode, from_x, from_y, to_x, to_y, wall_north,
                    wall_east, wall_south, wall_west, diag_en, output ready);
endinterface

interface wmap_res_if import wmap_pkg::*; ();
    logic valid;
    logic ready;
    logic move_allowed;
    logic read_north;
    logic read_east;
    logic read_south;
    logic read_west;
    logic read_known;
    logic accepted;

    modport source (output valid, move_allowed, read_north, read_east, read_south,
                    read_west, read_known, accepted, input ready);
    modport sink   (input valid, move_allowed, read_north, read_east, read_south,
                    read_west, read_known, accepted, output ready);
endinterface

interface wmap_cfg_if import wmap_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GRID_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wmap_store.sv =====
// Wall store: single-port cell memory with registered read and per-entry valid bits.
// Depends on wmap_pkg.
module wmap_store import wmap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output cell_t      rdata
);

    cell_t            mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    cell_t            rd_word_reg;
    logic             rd_valid_reg;

    // Memory array: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rd_word_reg <= mem[req.addr];
            end
        end
    end

    // Valid bits: an entry never written reads as zero (no walls, unknown)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (req.en)
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            else
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/core/wmap_seq.sv =====
// Request sequencer: latches a request, walks the store port through up to four
// accesses, folds the wall checks and loads the result register.
// Depends on wmap_pkg and wmap_ifs.
module wmap_seq import wmap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wmap_cmd_if.sink          cmd,
    wmap_res_if.source        res,
    input  logic [GRID_W-1:0] grid_width,
    input  logic [GRID_W-1:0] grid_height,
    output store_req_t        store_req,
    input  cell_t             store_rdata
);

    state_t state_reg, state_next;

    // Latched request
    op_t                       op_reg;
    logic signed [COORD_W-1:0] fx_reg, fy_reg, tx_reg, ty_reg;
    logic [3:0]                walls_reg;
    logic                      diag_reg;

    // Check accumulators
    logic  mv_ok_reg, mv_ok_next;
    cell_t rd_word_reg;

    // Result register
    logic res_valid_reg;
    logic res_move_reg, res_n_reg, res_e_reg, res_s_reg, res_w_reg, res_k_reg, res_acc_reg;

    // Decode of the latched request
    logic [DIM_W-1:0]        w_eff, h_eff;
    logic                    on_from, on_to;
    logic signed [COORD_W:0] dx, dy;
    logic                    dx_p1, dx_m1, dx_0, dy_p1, dy_m1, dy_0;
    logic                    orth, diag_geo, diag_step, op_ok;
    cell_t                   step_mask, back_mask, vmask, hmask;
    addr_t                   addr_from, addr_to, addr_c1, addr_c2;
    logic                    slot_free;

    // Grid size clamped to the built size
    always_comb
    begin
        w_eff = ({1'b0, grid_width}  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)
                                                            : {1'b0, grid_width};
        h_eff = ({1'b0, grid_height} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                            : {1'b0, grid_height};
    end

    // Bounds, step geometry and wall masks
    always_comb
    begin
        on_from = !fx_reg[COORD_W-1] && !fy_reg[COORD_W-1]
                  && ({1'b0, fx_reg[COORD_W-2:0]} < w_eff)
                  && ({1'b0, fy_reg[COORD_W-2:0]} < h_eff);
        on_to   = !tx_reg[COORD_W-1] && !ty_reg[COORD_W-1]
                  && ({1'b0, tx_reg[COORD_W-2:0]} < w_eff)
                  && ({1'b0, ty_reg[COORD_W-2:0]} < h_eff);

        dx = {tx_reg[COORD_W-1], tx_reg} - {fx_reg[COORD_W-1], fx_reg};
        dy = {ty_reg[COORD_W-1], ty_reg} - {fy_reg[COORD_W-1], fy_reg};
        dx_p1 = (dx == (COORD_W+1)'(1));
        dx_m1 = (dx == '1);
        dx_0  = (dx == '0);
        dy_p1 = (dy == (COORD_W+1)'(1));
        dy_m1 = (dy == '1);
        dy_0  = (dy == '0);

        orth      = ((dx_p1 || dx_m1) && dy_0) || (dx_0 && (dy_p1 || dy_m1));
        diag_geo  = (dx_p1 || dx_m1) && (dy_p1 || dy_m1);
        diag_step = diag_reg && diag_geo;

        // Wall crossed on the source side and its partner on the far side
        step_mask = dx_p1 ? MASK_E : dx_m1 ? MASK_W : dy_p1 ? MASK_N : MASK_S;
        back_mask = dx_p1 ? MASK_W : dx_m1 ? MASK_E : dy_p1 ? MASK_S : MASK_N;
        vmask     = dy_p1 ? MASK_N : MASK_S;
        hmask     = dx_p1 ? MASK_E : MASK_W;

        case (op_reg)
            OP_WRITE_CELL:  op_ok = on_from;
            OP_REMOVE_WALL: op_ok = on_from && on_to && orth;
            OP_MOVE_QUERY:  op_ok = on_from && on_to;
            OP_READ_CELL:   op_ok = on_from;
            default:        op_ok = 1'b0;
        endcase
    end

    // Cell addresses; only used when the cells are on the grid
    always_comb
    begin
        addr_from = cell_addr(fx_reg[GRID_W-1:0], fy_reg[GRID_W-1:0]);
        addr_to   = cell_addr(tx_reg[GRID_W-1:0], ty_reg[GRID_W-1:0]);
        addr_c1   = cell_addr(fx_reg[GRID_W-1:0], ty_reg[GRID_W-1:0]);
        addr_c2   = cell_addr(tx_reg[GRID_W-1:0], fy_reg[GRID_W-1:0]);
    end

    assign slot_free = !res_valid_reg || res.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_P0;
                end
            end
            ST_P0:
            begin
                if (!op_ok || op_reg == OP_WRITE_CELL)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_P1;
                end
            end
            ST_P1:
            begin
                if (op_reg == OP_REMOVE_WALL || (op_reg == OP_MOVE_QUERY && diag_step))
                begin
                    state_next = ST_P2;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_P2:   state_next = ST_P3;
            ST_P3:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Store port and check folding per step
    always_comb
    begin
        store_req  = '0;
        mv_ok_next = mv_ok_reg;
        unique case (state_reg)
            ST_P0:
            begin
                store_req.en    = op_ok;
                store_req.we    = (op_reg == OP_WRITE_CELL);
                store_req.addr  = addr_from;
                store_req.wdata = {1'b1, walls_reg[3], walls_reg[2], walls_reg[1],
                                   walls_reg[0]};
                mv_ok_next      = orth || diag_step;
            end
            ST_P1:
            begin
                if (op_reg == OP_REMOVE_WALL)
                begin
                    store_req.en    = 1'b1;
                    store_req.we    = 1'b1;
                    store_req.addr  = addr_from;
                    store_req.wdata = (store_rdata & ~step_mask) | MASK_K;
                end
                else if (op_reg == OP_MOVE_QUERY)
                begin
                    store_req.en   = diag_step;
                    store_req.addr = addr_c1;
                    if (diag_step)
                    begin
                        mv_ok_next = mv_ok_reg && ((store_rdata & (vmask | hmask)) == '0);
                    end
                    else
                    begin
                        mv_ok_next = mv_ok_reg && ((store_rdata & step_mask) == '0);
                    end
                end
            end
            ST_P2:
            begin
                store_req.en = 1'b1;
                if (op_reg == OP_REMOVE_WALL)
                begin
                    store_req.addr = addr_to;
                end
                else
                begin
                    store_req.addr = addr_c2;
                    mv_ok_next     = mv_ok_reg && ((store_rdata & hmask) == '0);
                end
            end
            ST_P3:
            begin
                if (op_reg == OP_REMOVE_WALL)
                begin
                    store_req.en    = 1'b1;
                    store_req.we    = 1'b1;
                    store_req.addr  = addr_to;
                    store_req.wdata = (store_rdata & ~back_mask) | MASK_K;
                end
                else
                begin
                    mv_ok_next = mv_ok_reg && ((store_rdata & vmask) == '0);
                end
            end
            default:
            begin
                store_req  = '0;
                mv_ok_next = mv_ok_reg;
            end
        endcase
    end

    assign cmd.ready = (state_reg == ST_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch, accumulators and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= op_t'(cmd.opcode);
            fx_reg    <= cmd.from_x;
            fy_reg    <= cmd.from_y;
            tx_reg    <= cmd.to_x;
            ty_reg    <= cmd.to_y;
            walls_reg <= {cmd.wall_west, cmd.wall_south, cmd.wall_east, cmd.wall_north};
            diag_reg  <= cmd.diag_en;
        end

        mv_ok_reg <= mv_ok_next;
        if (state_reg == ST_P1)
        begin
            rd_word_reg <= store_rdata;
        end

        if (state_reg == ST_FIN && slot_free)
        begin
            res_acc_reg  <= op_ok;
            res_move_reg <= (op_reg == OP_MOVE_QUERY) && op_ok && mv_ok_reg;
            if (op_reg == OP_READ_CELL)
            begin
                res_n_reg <= op_ok ? rd_word_reg[0] : 1'b1;
                res_e_reg <= op_ok ? rd_word_reg[1] : 1'b1;
                res_s_reg <= op_ok ? rd_word_reg[2] : 1'b1;
                res_w_reg <= op_ok ? rd_word_reg[3] : 1'b1;
                res_k_reg <= op_ok ? rd_word_reg[4] : 1'b0;
            end
            else
            begin
                res_n_reg <= 1'b0;
                res_e_reg <= 1'b0;
                res_s_reg <= 1'b0;
                res_w_reg <= 1'b0;
                res_k_reg <= 1'b0;
            end
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.move_allowed = res_move_reg;
    assign res.read_north   = res_n_reg;
    assign res.read_east    = res_e_reg;
    assign res.read_south   = res_s_reg;
    assign res.read_west    = res_w_reg;
    assign res.read_known   = res_k_reg;
    assign res.accepted     = res_acc_reg;

endmodule

// ===== rtl/core/maze_wall_map_core.sv =====
// Maze wall map core. One request at a time; the sequencer passes through its states:
// write cell and rejected requests P0 and FIN, read cell and other move queries P0, P1
// and FIN, diagonal query and wall removal P0 to P3 and FIN. A new request is taken once
// the last leaves FIN, which holds while one finished result waits in the result register.
// Reset (rst_n, async, low): grid registers to 16, all cell valid bits cleared at once.
// Depends on wmap_pkg, wmap_ifs, wmap_store and wmap_seq.
module maze_wall_map_core import wmap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wmap_cmd_if.sink   cmd,
    wmap_res_if.source res,
    wmap_cfg_if.sink   cfg
);

    logic [GRID_W-1:0] grid_width_reg;
    logic [GRID_W-1:0] grid_height_reg;
    store_req_t        store_req;
    cell_t             store_rdata;

    assign cfg.ready = 1'b1;

    // Grid size registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    wmap_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .store_req   (store_req),
        .store_rdata (store_rdata)
    );

    wmap_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .rdata (store_rdata)
    );

endmodule
